FILE: design/mcptb_pkg.sv
package mcptb_pkg;

  // Bank size; only the first 16 timers can be addressed by a request.
  localparam int NUM_TIMERS = 16;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  localparam logic [15:0] STOPPED_COUNT = 16'hFFFF;

  // Operation codes
  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_INIT = 3'd1;
  localparam logic [2:0] OP_STOP = 3'd2;
  localparam logic [2:0] OP_POLL = 3'd3;
  localparam logic [2:0] OP_SET  = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  timer_index;
    logic [15:0] period;
    logic [15:0] start_count;
  } req_t;

  typedef struct packed {
    logic       status;
    logic       fired;
    logic [3:0] fired_index;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_TICK,
    S_POLL,
    S_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_req;
    logic clr_ptr;
    logic adv_ptr;
    logic do_single;
    logic do_tick;
    logic do_poll;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       ptr_last;
    logic       poll_hit;
  } stat_t;

endpackage

FILE: design/mcptb_dp.sv
module mcptb_dp
  import mcptb_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  req_t  req,
  input  cmd_t  cmd,
  output stat_t stat,
  output rsp_t  rsp
);

  logic [15:0]      counter [NUM_TIMERS];
  logic [15:0]      period  [NUM_TIMERS];
  req_t             req_q;
  logic [IDX_W-1:0] ptr;
  rsp_t             result;
  rsp_t             rsp_q;

  logic [15:0]      cnt_rd;
  logic [15:0]      per_rd;
  logic             hit;
  logic             addressable;
  logic [IDX_W-1:0] wr_idx;

  assign cnt_rd      = counter[ptr];
  assign per_rd      = period[ptr];
  assign hit         = (per_rd != 16'd0) && (cnt_rd != STOPPED_COUNT) && (cnt_rd >= per_rd);
  assign addressable = 32'(req_q.timer_index) < NUM_TIMERS;
  assign wr_idx      = IDX_W'(req_q.timer_index);

  assign stat.op       = req_q.op;
  assign stat.ptr_last = (ptr == IDX_W'(NUM_TIMERS - 1));
  assign stat.poll_hit = hit;
  assign rsp           = rsp_q;

  // Request and output holding registers
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q <= req;
    end
    if (cmd.load_out) begin
      rsp_q <= result;
    end
  end

  // Scan pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (cmd.clr_ptr) begin
      ptr <= '0;
    end else if (cmd.adv_ptr && !stat.ptr_last) begin
      ptr <= ptr + 1'b1;
    end
  end

  // Result accumulator
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      result <= '0;
    end else if (cmd.do_single && req_q.op == OP_INIT && req_q.period == 16'd0) begin
      result.status <= 1'b1;
    end else if (cmd.do_poll && hit) begin
      result.fired       <= 1'b1;
      result.fired_index <= 4'(ptr);
    end
  end

  // Timer tables
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        counter[i] <= STOPPED_COUNT;
        period[i]  <= 16'd0;
      end
    end else if (cmd.do_tick) begin
      if (cnt_rd != STOPPED_COUNT) begin
        counter[ptr] <= cnt_rd + 16'd1;
      end
    end else if (cmd.do_poll) begin
      if (hit) begin
        counter[ptr] <= 16'd0;
      end
    end else if (cmd.do_single && addressable) begin
      case (req_q.op)
        OP_INIT: begin
          if (req_q.period != 16'd0) begin
            period[wr_idx]  <= req_q.period;
            counter[wr_idx] <= req_q.start_count;
          end
        end
        OP_STOP: begin
          counter[wr_idx] <= STOPPED_COUNT;
        end
        OP_SET: begin
          counter[wr_idx] <= req_q.start_count;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: design/mcptb_ctrl.sv
module mcptb_ctrl
  import mcptb_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  output logic  rsp_valid,
  input  logic  rsp_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid;

  assign rsp_valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.op == OP_TICK) begin
          state_next = S_TICK;
        end else if (stat.op == OP_POLL) begin
          state_next = S_POLL;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_TICK: begin
        if (stat.ptr_last) begin
          state_next = S_FINISH;
        end
      end
      S_POLL: begin
        if (stat.poll_hit || stat.ptr_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid || rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready    = 1'b1;
        cmd.load_req = req_valid;
        cmd.clr_ptr  = 1'b1;
      end
      S_DECODE: begin
        cmd.do_single = (stat.op != OP_TICK) && (stat.op != OP_POLL);
      end
      S_TICK: begin
        cmd.do_tick = 1'b1;
        cmd.adv_ptr = 1'b1;
      end
      S_POLL: begin
        cmd.do_poll = 1'b1;
        cmd.adv_ptr = 1'b1;
      end
      S_FINISH: begin
        cmd.load_out = !out_valid || rsp_ready;
      end
      default: begin
      end
    endcase
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> state == S_DECODE)
    else $error("accepted request did not start work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || rsp_ready))
    else $error("output register overwritten while held");

  a_poll_continues: assert property (@(posedge clk) disable iff (rst)
    state == S_POLL && !stat.poll_hit && !stat.ptr_last |=> state == S_POLL)
    else $error("poll scan ended early");

  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FINISH)
    else $error("response raised outside finish");

endmodule

FILE: design/multi_channel_periodic_timer_bank.sv
// Bank of NUM_TIMERS periodic 16-bit timers driven by one request channel. Each request
// returns exactly one response, in order. Tick and poll walk the bank through a single
// scan pointer, one timer per cycle, so a tick visits every timer and a poll stops at the
// first expired timer; init, stop and set_count touch at most one timer. The scan
// pointer and the one read/write port on each table set this pace. A finished response
// waits in an output register, so the next request is accepted and worked on while the
// previous response is still held; the block stalls only when a second response is ready
// before the first has been taken. A counter of 0xFFFF means stopped, a period of zero
// means disabled, and only timers 0 to 15 can be addressed.
module multi_channel_periodic_timer_bank
  import mcptb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  cmd_t  cmd;
  stat_t stat;

  // Sequence each request: decode, scan or single write, then hand off the response.
  mcptb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold the counter and period tables, the scan pointer and the response register.
  mcptb_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule

FILE: dv/tb_top.sv
module tb_top;
  import mcptb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Opcodes the block does not define; they must come back as all-zero results.
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  // Number of random requests after the directed opener.
  localparam int RANDOM_REQS = 950;
  // Watchdog limit on the whole run, with a wide margin over the worst case.
  localparam int CYCLE_LIMIT = 400000;
  // Quiet cycles after the last response, enough for one full scan of the bank.
  localparam int DRAIN_CYCLES = 2 * NUM_TIMERS + 8;
  // Print at most this many mismatch lines; later ones are still counted.
  localparam int MAX_REPORTS = 40;

  // Receiver back-pressure patterns.
  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_PERIODIC,
    RDY_MOSTLY
  } ready_mode_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // Our own copy of the timer bank state, advanced at each accepted request.
  logic [15:0] timer_count  [NUM_TIMERS];
  logic [15:0] timer_period [NUM_TIMERS];

  req_t pending_reqs [$];
  rsp_t expected_rsps [$];

  int reqs_total;
  int reqs_accepted;
  int rsps_checked;
  int mismatch_count;
  int expiries_seen;
  int rejects_seen;
  int cycle_count;

  // Driver pacing state.
  logic req_fire = 1'b0;
  int burst_left;
  int gap_left;

  // Receiver pacing state.
  ready_mode_e ready_mode = RDY_ALWAYS;
  int ready_hold;
  int ready_period = 3;
  int ready_phase;

  multi_channel_periodic_timer_bank DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Bring the bank model to its reset state: every timer stopped and disabled.
  function automatic void clear_timer_bank();
    for (int i = 0; i < NUM_TIMERS; i++) begin
      timer_count[i]  = STOPPED_COUNT;
      timer_period[i] = '0;
    end
  endfunction

  // Apply one request to the bank model and return the response it must produce.
  function automatic rsp_t apply_timer_request(req_t r);
    rsp_t res;
    logic hit;
    res = '0;
    hit = 1'b0;
    case (r.op)
      OP_TICK: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (timer_count[i] != STOPPED_COUNT)
            timer_count[i] = timer_count[i] + 16'd1;
        end
      end
      OP_INIT: begin
        if (r.period == '0) begin
          res.status = 1'b1;
        end else if (int'(r.timer_index) < NUM_TIMERS) begin
          timer_period[r.timer_index] = r.period;
          timer_count[r.timer_index]  = r.start_count;
        end
      end
      OP_STOP: begin
        if (int'(r.timer_index) < NUM_TIMERS)
          timer_count[r.timer_index] = STOPPED_COUNT;
      end
      OP_POLL: begin
        // Lowest index wins; only that one counter is cleared.
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (!hit && timer_period[i] != '0 && timer_count[i] != STOPPED_COUNT &&
              timer_count[i] >= timer_period[i]) begin
            hit = 1'b1;
            timer_count[i] = '0;
            res.fired = 1'b1;
            res.fired_index = 4'(i);
          end
        end
      end
      OP_SET: begin
        if (int'(r.timer_index) < NUM_TIMERS)
          timer_count[r.timer_index] = r.start_count;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic req_t make_req(logic [2:0] op, logic [3:0] idx, logic [15:0] per,
                                    logic [15:0] start);
    req_t r;
    r.op = op;
    r.timer_index = idx;
    r.period = per;
    r.start_count = start;
    return r;
  endfunction

  task automatic report(string what, int want, int got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch at response %0d: %s expected %0h got %0h", rsps_checked, what, want,
               got);
  endtask

  // Driver: present requests at the falling edge, in bursts separated by random gaps.
  always @(negedge clk) begin : drive_req
    logic nxt_valid;
    req_t nxt_req;
    nxt_valid = req_valid;
    nxt_req = req;
    // Hold the current request until the handshake has taken it.
    if (!rst && !(req_valid && !req_fire)) begin
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_reqs.size() > 0) begin
        nxt_req = pending_reqs.pop_front();
        nxt_valid = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // Close the burst; sometimes run straight into the next one.
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
    req_valid <= nxt_valid;
    req <= nxt_req;
  end

  // Receiver: stall on a pattern that is redrawn after a random hold.
  always @(negedge clk) begin
    if (ready_hold == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      ready_hold = $urandom_range(50, 300);
      ready_period = $urandom_range(2, 7);
      ready_phase = 0;
    end else begin
      ready_hold--;
      ready_phase++;
    end
    case (ready_mode)
      RDY_ALWAYS:   rsp_ready <= 1'b1;
      RDY_COIN:     rsp_ready <= ($urandom_range(0, 1) == 1);
      RDY_PERIODIC: rsp_ready <= ((ready_phase % ready_period) == 0);
      default:      rsp_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Monitor: predict each accepted request and check each accepted response in order.
  always @(posedge clk) begin : watch_bank
    rsp_t want;
    if (rst) begin
      req_fire <= 1'b0;
    end else begin
      req_fire <= req_valid && req_ready;
      if (req_valid && req_ready) begin
        expected_rsps.push_back(apply_timer_request(req));
        reqs_accepted++;
      end
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          report("response with nothing outstanding, fields", 0, int'(rsp));
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.status !== want.status)
            report("status", int'(want.status), int'(rsp.status));
          if (rsp.fired !== want.fired)
            report("fired", int'(want.fired), int'(rsp.fired));
          if (rsp.fired_index !== want.fired_index)
            report("fired_index", int'(want.fired_index), int'(rsp.fired_index));
          if (want.fired)
            expiries_seen++;
          if (want.status)
            rejects_seen++;
        end
        rsps_checked++;
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d requests accepted", cycle_count,
               reqs_accepted, reqs_total);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : run_test
    int dice;
    logic [3:0] idx;
    logic [15:0] per;
    logic [15:0] start;
    req_t r;

    clear_timer_bank();

    // Directed opener.
    // Poll right after reset: nothing is enabled, so nothing fires.
    pending_reqs.push_back(make_req(OP_POLL, 4'd0, 16'h0000, 16'h0000));
    // Init with zero period is rejected and changes nothing.
    pending_reqs.push_back(make_req(OP_INIT, 4'd0, 16'h0000, 16'h0005));
    // Init with a stopped start count: period stored, timer stays stopped.
    pending_reqs.push_back(make_req(OP_INIT, 4'd15, 16'hFFFF, 16'hFFFF));
    pending_reqs.push_back(make_req(OP_INIT, 4'd3, 16'h0002, 16'h0000));
    pending_reqs.push_back(make_req(OP_TICK, 4'd0, 16'h0000, 16'h0000));
    pending_reqs.push_back(make_req(OP_TICK, 4'd15, 16'hFFFF, 16'hFFFF));
    // Timer 3 reached its period; poll fires it and clears it.
    pending_reqs.push_back(make_req(OP_POLL, 4'd15, 16'hFFFF, 16'hFFFF));
    // Set count one below stopped; the next tick climbs into the stopped value.
    pending_reqs.push_back(make_req(OP_SET, 4'd15, 16'h0000, 16'hFFFE));
    pending_reqs.push_back(make_req(OP_INIT, 4'd7, 16'h0001, 16'hFFFE));
    pending_reqs.push_back(make_req(OP_TICK, 4'd0, 16'h0000, 16'h0000));
    // Set count on a disabled timer: it must never fire.
    pending_reqs.push_back(make_req(OP_SET, 4'd5, 16'hFFFF, 16'h1234));
    pending_reqs.push_back(make_req(OP_POLL, 4'd0, 16'h0000, 16'h0000));
    // Undefined opcodes with every field bit set.
    pending_reqs.push_back(make_req(OP_RSVD5, 4'd15, 16'hFFFF, 16'hFFFF));
    pending_reqs.push_back(make_req(OP_RSVD6, 4'd15, 16'hFFFF, 16'hFFFF));
    pending_reqs.push_back(make_req(OP_RSVD7, 4'd15, 16'hFFFF, 16'hFFFF));
    // Several expired at once: polls must take them lowest index first.
    pending_reqs.push_back(make_req(OP_INIT, 4'd10, 16'h8000, 16'h9000));
    pending_reqs.push_back(make_req(OP_INIT, 4'd2, 16'h0001, 16'h0005));
    pending_reqs.push_back(make_req(OP_INIT, 4'd9, 16'h0001, 16'h0001));
    pending_reqs.push_back(make_req(OP_POLL, 4'd0, 16'h0000, 16'h0000));
    pending_reqs.push_back(make_req(OP_POLL, 4'd0, 16'h0000, 16'h0000));
    pending_reqs.push_back(make_req(OP_POLL, 4'd0, 16'h0000, 16'h0000));
    // Stop a running timer; a poll after that finds it idle.
    pending_reqs.push_back(make_req(OP_STOP, 4'd3, 16'h0000, 16'h0000));
    pending_reqs.push_back(make_req(OP_POLL, 4'd0, 16'h0000, 16'h0000));

    // Random traffic: mostly ticks and polls over a bank kept busy by inits and
    // count loads, with small periods so timers expire often.
    for (int n = 0; n < RANDOM_REQS; n++) begin
      dice = $urandom_range(0, 99);
      idx = 4'($urandom_range(0, 15));
      per = 16'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 12));
      case ($urandom_range(0, 3))
        0: start = 16'($urandom_range(0, per));
        1: start = 16'hFFF0 + 16'($urandom_range(0, 15));   // close to wrapping into stopped
        2: start = 16'($urandom);
        default: start = 16'($urandom_range(0, 20));
      endcase
      // Don't-care fields of tick and poll carry random bits.
      r = make_req(OP_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
      if (dice < 35) begin
        r.op = OP_TICK;
      end else if (dice < 60) begin
        r.op = OP_POLL;
      end else if (dice < 73) begin
        r = make_req(OP_INIT, idx, per, start);
      end else if (dice < 83) begin
        r = make_req(OP_SET, idx, per, start);
      end else if (dice < 92) begin
        r = make_req(OP_STOP, idx, per, start);
      end else if (dice < 96) begin
        r.op = 3'($urandom_range(int'(OP_RSVD5), int'(OP_RSVD7)));
      end else begin
        r = make_req(OP_INIT, idx, 16'h0000, start);
      end
      pending_reqs.push_back(r);
    end
    reqs_total = pending_reqs.size();

    // Hold reset, then release it at a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (reqs_accepted < reqs_total) @(posedge clk);
    while (expected_rsps.size() != 0) @(posedge clk);
    // Let any stray response show up before closing.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d requests (%0d directed) through the timer bank in %0d cycles",
             reqs_total, reqs_total - RANDOM_REQS, cycle_count);
    $display("saw %0d expiries, %0d rejected inits, %0d mismatches", expiries_seen,
             rejects_seen, mismatch_count);
    if (mismatch_count == 0 && rsps_checked == reqs_total) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/mcptb_pkg.sv
design/mcptb_dp.sv
design/mcptb_ctrl.sv
design/multi_channel_periodic_timer_bank.sv
dv/tb_top.sv
